// File: design/mbrq_pkg.sv
// Package for the message byte ring queue: request/response payload types,
// the issue bundle between the pointer stage and the response stage, and codes.
// No dependencies.
package mbrq_pkg;

    localparam int BYTE_W = 8;
    localparam int PEND_W = 9;

    localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

    // func codes
    localparam logic FUNC_STORE    = 1'b0;
    localparam logic FUNC_TX_READY = 1'b1;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] data_byte;
    } req_t;

    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              busy_res;
        logic [PEND_W-1:0] pending_messages;
        logic              overrun;
    } rsp_t;

    // What the pointer stage decided for one accepted request
    typedef struct packed {
        logic rd;    // byte read from the ring, data arrives next cycle
        logic term;  // zero byte stored, one more message pending
        logic ovr;   // store dropped on a full ring
    } issue_t;

endpackage

// File: design/message_byte_ring_queue.sv
// Top level of the message byte ring queue: pointer stage, ring RAM and
// response stage. Uses mbrq_pkg, mbrq_ctrl, mbrq_ram, mbrq_resp.
//
//   channel  signals                       payload           direction
//   request  req_valid / req_ready / req   mbrq_pkg::req_t   in
//   response rsp_valid / rsp_ready / rsp   mbrq_pkg::rsp_t   out
//
// One request accepted per cycle while responses are taken; its response
// passes through the registered RAM read and then the output register.
// Reset clears pointers, fill level and pending count; the ring RAM itself
// is not cleared and needs no clearing pass.
// With rsp_ready low the response holds, one more request is taken into the
// middle stage, then req_ready drops until the response is taken.
module message_byte_ring_queue #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  mbrq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mbrq_pkg::rsp_t rsp
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic                        accept;
    mbrq_pkg::issue_t            issue;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [mbrq_pkg::BYTE_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [mbrq_pkg::BYTE_W-1:0] ram_rdata;

    assign accept = req_valid && req_ready;

    mbrq_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .issue     (issue),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    mbrq_ram #(
        .WIDTH (mbrq_pkg::BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mbrq_resp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_resp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .issue     (issue),
        .ram_rdata (ram_rdata),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// File: design/mbrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/mbrq_ctrl.sv
// Pointer stage: write/read pointers, fill level and the count of bytes up to
// the last stored terminator. Drives the ring RAM ports. Uses mbrq_pkg.
module mbrq_ctrl #(
    parameter int BUFFER_DEPTH = 256,
    localparam int AW = $clog2(BUFFER_DEPTH),
    localparam int FW = $clog2(BUFFER_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  mbrq_pkg::req_t                req,
    output mbrq_pkg::issue_t              issue,
    output logic                          ram_we,
    output logic [AW-1:0]                 ram_waddr,
    output logic [mbrq_pkg::BYTE_W-1:0]   ram_wdata,
    output logic                          ram_re,
    output logic [AW-1:0]                 ram_raddr
);

    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [FW-1:0] fill_reg, fill_next;
    // Bytes from the read pointer through the last stored terminator;
    // nonzero exactly while a terminated message is pending.
    logic [FW-1:0] sendable_reg, sendable_next;

    logic full;
    logic is_store;
    logic is_term;
    logic can_read;
    logic do_store;
    logic do_read;

    assign full     = (fill_reg == FW'(BUFFER_DEPTH));
    assign is_store = (req.func == mbrq_pkg::FUNC_STORE);
    assign is_term  = (req.data_byte == mbrq_pkg::TERMINATOR);
    assign can_read = (sendable_reg != '0);
    assign do_store = accept && is_store && !full;
    assign do_read  = accept && !is_store && can_read;

    assign issue.rd   = !is_store && can_read;
    assign issue.term = is_store && !full && is_term;
    assign issue.ovr  = is_store && full;

    always_comb
    begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        fill_next     = fill_reg;
        sendable_next = sendable_reg;
        if (do_store)
        begin
            wp_next   = (wp_reg == AW'(BUFFER_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
            if (is_term)
            begin
                sendable_next = fill_reg + 1'b1;
            end
        end
        else if (do_read)
        begin
            rp_next       = (rp_reg == AW'(BUFFER_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            fill_next     = fill_reg - 1'b1;
            sendable_next = sendable_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            fill_reg     <= '0;
            sendable_reg <= '0;
        end
        else
        begin
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            fill_reg     <= fill_next;
            sendable_reg <= sendable_next;
        end
    end

    assign ram_we    = do_store;
    assign ram_waddr = wp_reg;
    assign ram_wdata = req.data_byte;
    assign ram_re    = do_read;
    assign ram_raddr = rp_reg;

`ifndef SYNTHESIS
    a_sendable_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        sendable_reg <= fill_reg)
        else $error("sendable bytes exceed fill level");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(BUFFER_DEPTH))
        else $error("fill level above ring depth");

    a_read_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        do_read |-> fill_reg != '0)
        else $error("ring read while empty");

    a_store_moves_wp: assert property (@(posedge clk) disable iff (!rst_n)
        do_store |=> wp_reg != $past(wp_reg))
        else $error("write pointer did not advance on store");
`endif

endmodule

// File: design/mbrq_resp.sv
// Response stage: holds the issued request while the RAM read completes,
// tracks the pending-message count and drives the output register.
// Uses mbrq_pkg.
module mbrq_resp #(
    parameter int BUFFER_DEPTH = 256,
    localparam int CW = $clog2(BUFFER_DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  mbrq_pkg::issue_t            issue,
    input  logic [mbrq_pkg::BYTE_W-1:0] ram_rdata,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output mbrq_pkg::rsp_t              rsp
);

    logic             s1_valid_reg;
    mbrq_pkg::issue_t s1_issue_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic             rsp_valid_reg, rsp_valid_next;
    mbrq_pkg::rsp_t   rsp_reg, rsp_next;

    logic accept;
    logic s1_advance;
    logic sent_zero;
    logic tx_go;

    assign s1_advance = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready  = !s1_valid_reg || s1_advance;
    assign accept     = req_valid && req_ready;

    assign sent_zero = s1_issue_reg.rd && (ram_rdata == mbrq_pkg::TERMINATOR);
    assign tx_go     = s1_issue_reg.rd && (ram_rdata != mbrq_pkg::TERMINATOR);

    always_comb
    begin
        count_next = count_reg;
        if (s1_advance)
        begin
            if (s1_issue_reg.term)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (sent_zero)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        rsp_next.tx_valid         = tx_go;
        rsp_next.tx_byte          = tx_go ? ram_rdata : '0;
        rsp_next.busy_res         = (count_next != '0);
        rsp_next.pending_messages = mbrq_pkg::PEND_W'(count_next);
        rsp_next.overrun          = s1_issue_reg.ovr;
    end

    // hold the result while the consumer stalls
    assign rsp_valid_next = s1_advance || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_issue_reg <= issue;
        end
        if (s1_advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_tx_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.tx_valid |-> rsp_reg.tx_byte != '0)
        else $error("transmitted byte is a terminator");

    a_overrun_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.overrun |-> !rsp_reg.tx_valid)
        else $error("dropped store reported a transmit");

    a_zero_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && sent_zero |-> count_reg != '0)
        else $error("terminator read with no message pending");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(BUFFER_DEPTH))
        else $error("pending count above ring depth");
`endif

endmodule
